/* hdl/row_soft_lock_tracker_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef ROW_SOFT_LOCK_TRACKER_CORE_DEFINES_SVH
`define ROW_SOFT_LOCK_TRACKER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RSLT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RSLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hdl/rslt_pkg.sv */
package rslt_pkg;
	localparam logic [1:0] ACT_ACCESS = 2'd0;
	localparam logic [1:0] ACT_ABORT = 2'd1;
	localparam logic [1:0] ACT_COMMIT = 2'd2;
	localparam logic [1:0] KIND_WRITER = 2'd0;
	localparam logic [1:0] KIND_READER = 2'd1;
	localparam logic [1:0] KIND_FINAL = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic access_kind;
		logic [63:0] txn_id;
		logic [63:0] commit_stamp;
		logic [63:0] txn_read_max_in;
		logic [63:0] txn_write_max_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0] entry_kind;
		logic [63:0] other_txn;
		logic [63:0] txn_read_max_out;
		logic [63:0] txn_write_max_out;
		logic status;
		logic set_overflow;
		logic last;
	} out_word_t;

	// Control handed from the sequencer to every cell of one set.
	typedef struct packed {
		logic rotate;
		logic do_remove;
		logic do_insert;
		logic [63:0] key;
	} cell_ctl_t;
endpackage

/* hdl/rslt_cell.sv */
module rslt_cell (
	input logic clk,
	input logic arst_n,
	input rslt_pkg::cell_ctl_t ctl,
	input logic left_valid,
	input logic [63:0] left_id,
	input logic left_ge,
	input logic right_valid,
	input logic [63:0] right_id,
	input logic [63:0] head_id,
	output logic valid,
	output logic [63:0] id,
	output logic ge,
	output logic match
);
	import rslt_pkg::*;

	logic valid_q;
	logic [63:0] id_q;
	logic ins_here;

	assign valid = valid_q;
	assign id = id_q;
	assign ge = valid_q && !(id_q < ctl.key);
	assign match = valid_q && id_q == ctl.key;
	assign ins_here = !left_ge && (ge || (!valid_q && left_valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.do_remove && ge) begin
			valid_q <= right_valid;
		end else if (ctl.do_insert && (left_ge || ins_here)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rotate && valid_q) begin
			id_q <= right_valid ? right_id : head_id;
		end else if (ctl.do_remove && ge) begin
			id_q <= right_id;
		end else if (ctl.do_insert && left_ge) begin
			id_q <= left_id;
		end else if (ctl.do_insert && ins_here) begin
			id_q <= ctl.key;
		end
	end
endmodule

/* hdl/rslt_set.sv */
module rslt_set #(
	parameter int SET_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input rslt_pkg::cell_ctl_t ctl,
	output logic [63:0] head_id,
	output logic has_key,
	output logic has_free
);
	import rslt_pkg::*;

	logic [SET_DEPTH+1:0] valid_c;
	logic [SET_DEPTH+1:0][63:0] id_c;
	logic [SET_DEPTH:0] ge_c;
	logic [SET_DEPTH-1:0] match_c;

	// Position 0 stands before the first cell and position SET_DEPTH + 1 after the last.
	assign valid_c[0] = 1'b1;
	assign id_c[0] = '0;
	assign ge_c[0] = 1'b0;
	assign valid_c[SET_DEPTH+1] = 1'b0;
	assign id_c[SET_DEPTH+1] = '0;

	for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
		rslt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.left_valid(valid_c[g]), .left_id(id_c[g]), .left_ge(ge_c[g]),
			.right_valid(valid_c[g+2]), .right_id(id_c[g+2]), .head_id(id_c[1]),
			.valid(valid_c[g+1]), .id(id_c[g+1]), .ge(ge_c[g+1]), .match(match_c[g])
		);
	end

	assign head_id = id_c[1];
	assign has_key = |match_c;
	assign has_free = !valid_c[SET_DEPTH];
endmodule

/* hdl/row_soft_lock_tracker_core.sv */
// One row's concurrency record. Each id set is a chain of SET_DEPTH cells that keeps its ids
// sorted and packed toward the first cell; an insert or a removal shifts the cells past the
// key by one place, and a walk rotates the chain so that each id reaches the first cell in
// ascending order. Abort, commit and unknown actions present their single final word, which is
// registered from the final state; the next word is accepted only after that. A read access
// sends the n ids of the write set one per cycle while the output is not stalled; a write
// access sends the ids of the read set and then of the write set. A stalled output word
// holds the walk until it is taken. One item is worked on at a time.
module row_soft_lock_tracker_core #(
	parameter int SET_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rslt_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rslt_pkg::out_word_t out_data
);
	import rslt_pkg::*;

	localparam int CNT_W = $clog2(SET_DEPTH + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [1:0] state_q;
	logic phase_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [CNT_W-1:0] wcnt_q;
	in_word_t req_q;
	logic [63:0] rlast_q;
	logic [63:0] wlast_q;
	out_word_t out_q;
	logic out_v_q;

	cell_ctl_t rctl;
	cell_ctl_t wctl;
	logic [63:0] rhead;
	logic [63:0] whead;
	logic rkey;
	logic wkey;
	logic rfree;
	logic wfree;

	logic out_free;
	logic walk_r;
	logic cur_any;
	logic [63:0] cur_head;
	logic [CNT_W-1:0] cur_cnt;
	logic is_acc;
	logic ovf;

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;
	assign is_acc = req_q.action == ACT_ACCESS;
	assign walk_r = req_q.access_kind && !phase_q;
	assign cur_cnt = walk_r ? rcnt_q : wcnt_q;
	assign cur_any = idx_q != cur_cnt;
	assign cur_head = walk_r ? rhead : whead;
	assign ovf = req_q.access_kind ? (!wkey && !wfree) : (!rkey && !rfree);

	always_comb begin
		rctl = '0;
		wctl = '0;
		rctl.key = req_q.txn_id;
		wctl.key = req_q.txn_id;
		if (state_q == ST_WALK && out_free && cur_any) begin
			rctl.rotate = walk_r;
			wctl.rotate = !walk_r;
		end
		if (state_q == ST_FINAL && out_free) begin
			if (is_acc) begin
				rctl.do_insert = !req_q.access_kind && !rkey && rfree;
				wctl.do_insert = req_q.access_kind && !wkey && wfree;
			end else if (req_q.action == ACT_ABORT || req_q.action == ACT_COMMIT) begin
				rctl.do_remove = !req_q.access_kind && rkey;
				wctl.do_remove = req_q.access_kind && wkey;
			end
		end
	end

	rslt_set #(.SET_DEPTH(SET_DEPTH)) u_rset (
		.clk(clk), .arst_n(arst_n), .ctl(rctl),
		.head_id(rhead), .has_key(rkey), .has_free(rfree)
	);
	rslt_set #(.SET_DEPTH(SET_DEPTH)) u_wset (
		.clk(clk), .arst_n(arst_n), .ctl(wctl),
		.head_id(whead), .has_key(wkey), .has_free(wfree)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			idx_q <= '0;
			rcnt_q <= '0;
			wcnt_q <= '0;
			out_v_q <= 1'b0;
			rlast_q <= '0;
			wlast_q <= '0;
		end else begin
			if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						phase_q <= 1'b0;
						idx_q <= '0;
						state_q <= in_data.action == ACT_ACCESS ? ST_WALK : ST_FINAL;
					end
				end
				ST_WALK: begin
					if (out_free) begin
						if (cur_any) begin
							out_v_q <= 1'b1;
							idx_q <= idx_q + 1'b1;
						end else if (walk_r) begin
							phase_q <= 1'b1;
							idx_q <= '0;
						end else begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
						if (rctl.do_insert) begin
							rcnt_q <= rcnt_q + 1'b1;
						end else if (rctl.do_remove) begin
							rcnt_q <= rcnt_q - 1'b1;
						end
						if (wctl.do_insert) begin
							wcnt_q <= wcnt_q + 1'b1;
						end else if (wctl.do_remove) begin
							wcnt_q <= wcnt_q - 1'b1;
						end
						if (req_q.action == ACT_COMMIT) begin
							if (req_q.access_kind && req_q.commit_stamp > wlast_q) begin
								wlast_q <= req_q.commit_stamp;
							end
							if (!req_q.access_kind && req_q.commit_stamp > rlast_q) begin
								rlast_q <= req_q.commit_stamp;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == ST_WALK && out_free && cur_any) begin
			out_q <= '0;
			out_q.entry_kind <= walk_r ? KIND_READER : KIND_WRITER;
			out_q.other_txn <= cur_head;
		end
		if (state_q == ST_FINAL && out_free) begin
			out_q <= '0;
			out_q.entry_kind <= KIND_FINAL;
			out_q.last <= 1'b1;
			out_q.txn_read_max_out <= req_q.txn_read_max_in;
			out_q.txn_write_max_out <= req_q.txn_write_max_in;
			if (is_acc) begin
				out_q.set_overflow <= ovf;
				if (req_q.txn_write_max_in < wlast_q) begin
					out_q.txn_write_max_out <= wlast_q;
				end
				if (req_q.access_kind && req_q.txn_read_max_in < rlast_q) begin
					out_q.txn_read_max_out <= rlast_q;
				end
			end
			out_q.status <= req_q.action == ACT_ABORT;
		end
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;
endmodule

/* hdl/rslt_checker.sv */
`include "row_soft_lock_tracker_core_defines.svh"
module rslt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rslt_pkg::out_word_t out_data
);
	import rslt_pkg::*;

	`RSLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`RSLT_ASSERT_IMP(a_last_final, out_valid && out_data.last, out_data.entry_kind == KIND_FINAL)
	`RSLT_ASSERT_IMP(a_id_clean, out_valid && !out_data.last, !out_data.status && !out_data.set_overflow)
	`RSLT_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall)
endmodule

bind row_soft_lock_tracker_core rslt_checker u_rslt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
